FILE: rtl/taie_pkg.sv
// ----------------------------------------------------------------------------
// taie_pkg
// Opcodes, widths and shared types of the three-address execute unit.
// ----------------------------------------------------------------------------
package taie_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned CMD_W  = 5;

    localparam logic [CMD_W-1:0] OP_ADD    = 5'd0;
    localparam logic [CMD_W-1:0] OP_SUB    = 5'd1;
    localparam logic [CMD_W-1:0] OP_MUL    = 5'd2;
    localparam logic [CMD_W-1:0] OP_DIV    = 5'd3;
    localparam logic [CMD_W-1:0] OP_MOD    = 5'd4;
    localparam logic [CMD_W-1:0] OP_SHL    = 5'd5;
    localparam logic [CMD_W-1:0] OP_SHR    = 5'd6;
    localparam logic [CMD_W-1:0] OP_EQ     = 5'd7;
    localparam logic [CMD_W-1:0] OP_NE     = 5'd8;
    localparam logic [CMD_W-1:0] OP_LT     = 5'd9;
    localparam logic [CMD_W-1:0] OP_LE     = 5'd10;
    localparam logic [CMD_W-1:0] OP_GT     = 5'd11;
    localparam logic [CMD_W-1:0] OP_GE     = 5'd12;
    localparam logic [CMD_W-1:0] OP_AND    = 5'd13;
    localparam logic [CMD_W-1:0] OP_OR     = 5'd14;
    localparam logic [CMD_W-1:0] OP_XOR    = 5'd15;
    localparam logic [CMD_W-1:0] OP_LAND   = 5'd16;
    localparam logic [CMD_W-1:0] OP_LOR    = 5'd17;
    localparam logic [CMD_W-1:0] OP_LNOT   = 5'd18;
    localparam logic [CMD_W-1:0] OP_BNOT   = 5'd19;
    localparam logic [CMD_W-1:0] OP_LBL    = 5'd20;
    localparam logic [CMD_W-1:0] OP_JMP    = 5'd21;
    localparam logic [CMD_W-1:0] OP_JTRUE  = 5'd22;
    localparam logic [CMD_W-1:0] OP_JFALSE = 5'd23;
    localparam logic [CMD_W-1:0] OP_COPY   = 5'd24;
    localparam logic [CMD_W-1:0] OP_PRN    = 5'd25;
    localparam logic [CMD_W-1:0] OP_END    = 5'd26;
    localparam logic [CMD_W-1:0] OP_SETVAR = 5'd27;

    typedef struct packed {
        logic [DATA_W-1:0] immediate;
        logic [IDX_W-1:0]  dest;
        logic [IDX_W-1:0]  src_b;
        logic [IDX_W-1:0]  src_a;
        logic [CMD_W-1:0]  cmd;
    } instr_t;

    typedef struct packed {
        logic              arith_error;
        logic              halt;
        logic [DATA_W-1:0] print_value;
        logic              print_valid;
        logic [IDX_W-1:0]  target_label;
        logic              branch_taken;
    } result_t;

    typedef struct packed {
        logic start;
        logic is_mod;
    } div_ctl_t;

    typedef struct packed {
        logic              done;
        logic              err;
        logic [DATA_W-1:0] value;
    } div_sts_t;

endpackage

FILE: rtl/taie_ram.sv
// ----------------------------------------------------------------------------
// taie_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module taie_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/taie_div.sv
// ----------------------------------------------------------------------------
// taie_div
// Radix-2 restoring signed divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module taie_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  taie_pkg::div_ctl_t        ctl,
    input  logic [taie_pkg::DATA_W-1:0] a,
    input  logic [taie_pkg::DATA_W-1:0] b,
    output taie_pkg::div_sts_t        sts
);
    import taie_pkg::*;

    logic              busy_reg, busy_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic              qneg_reg, qneg_next;
    logic              rneg_reg, rneg_next;
    logic              mod_reg, mod_next;
    logic              done_reg, done_next;
    logic              err_reg, err_next;
    logic [DATA_W-1:0] val_reg, val_next;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] qres, rres;

    always_comb
    begin
        trial = {r_reg, q_reg[DATA_W-1]};
        diff  = trial - {1'b0, d_reg};
        qres  = qneg_reg ? (~q_reg + 1'b1) : q_reg;
        rres  = rneg_reg ? (~r_reg + 1'b1) : r_reg;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        mod_next  = mod_reg;
        done_next = 1'b0;
        err_next  = err_reg;
        val_next  = val_reg;
        if (ctl.start)
        begin
            if (b == '0 || (a == {1'b1, {(DATA_W-1){1'b0}}} && b == '1))
            begin
                done_next = 1'b1;
                err_next  = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = 6'(DATA_W);
                q_next    = a[DATA_W-1] ? (~a + 1'b1) : a;
                d_next    = b[DATA_W-1] ? (~b + 1'b1) : b;
                r_next    = '0;
                qneg_next = a[DATA_W-1] ^ b[DATA_W-1];
                rneg_next = a[DATA_W-1];
                mod_next  = ctl.is_mod;
                err_next  = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                val_next  = mod_reg ? rres : qres;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
                if (!diff[DATA_W])
                begin
                    r_next = diff[DATA_W-1:0];
                    q_next = {q_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    r_next = trial[DATA_W-1:0];
                    q_next = {q_reg[DATA_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
        mod_reg  <= mod_next;
        err_reg  <= err_next;
        val_reg  <= val_next;
    end

    assign sts.done  = done_reg;
    assign sts.err   = err_reg;
    assign sts.value = val_reg;

endmodule

FILE: rtl/three_address_ir_execute_unit.sv
// ----------------------------------------------------------------------------
// three_address_ir_execute_unit
// Executes three-address instructions against a RAM-held variable file.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one instruction per transfer; tdata packs cmd, src_a,
//   src_b, dest, immediate from bit 0 up. m_axis returns one result per
//   instruction; tdata packs branch_taken, target_label, print_valid,
//   print_value, halt, arith_error from bit 0 up.
//   One instruction at a time: the variable file is read in ST_RDA and
//   ST_RDB (one RAM read port), then the op executes and writes back. Ops
//   that write a variable write back in ST_DIV before ST_OUT presents the
//   result; jumps, print, end and no-ops go from ST_EXEC straight to ST_OUT.
//   div and mod wait in ST_DIV for the one-bit-per-cycle divider, which
//   flags a divide error without iterating. s_axis_tready is high only when
//   idle, so with a ready receiver the next transfer is accepted in ST_IDLE
//   once the result has been taken in ST_OUT.
//   After reset a clearing pass writes zero to every variable, during which
//   no instruction is accepted.
//   The result sits in an output register until taken; a stalled receiver
//   holds the block before it accepts the next instruction.
// ----------------------------------------------------------------------------
module three_address_ir_execute_unit #(
    parameter int unsigned NUM_VARS   = 256,
    parameter int unsigned NUM_LABELS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[4:0], src_a[12:5], src_b[20:13], dest[28:21], immediate[60:29]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // branch_taken[0], target_label[8:1], print_valid[9], print_value[41:10],
    // halt[42], arith_error[43]
    output logic [47:0] m_axis_tdata
);
    import taie_pkg::*;

    localparam int unsigned AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RDA   = 3'd2;
    localparam logic [2:0] ST_RDB   = 3'd3;
    localparam logic [2:0] ST_EXEC  = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [AW:0]       clr_reg, clr_next;
    instr_t            ins_reg, ins_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic              ain_reg, ain_next;
    logic              bin_reg, bin_next;
    result_t           res_reg, res_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    div_ctl_t          dctl;
    div_sts_t          dsts;

    logic [DATA_W-1:0] alu;
    logic [DATA_W-1:0] prod;
    logic              lt, eq;
    logic              dest_in;
    logic              jcond;

    taie_ram #(.WIDTH(DATA_W), .DEPTH(NUM_VARS)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    taie_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dctl),
        .a     (a_reg),
        .b     (b_reg),
        .sts   (dsts)
    );

    assign dest_in = {{(32-IDX_W){1'b0}}, ins_reg.dest} < NUM_VARS;
    assign eq      = a_reg == b_reg;
    assign lt      = $signed(a_reg) < $signed(b_reg);
    assign prod    = a_reg * b_reg;

    always_comb
    begin
        case (ins_reg.cmd)
            OP_ADD:    alu = a_reg + b_reg;
            OP_SUB:    alu = a_reg - b_reg;
            OP_MUL:    alu = prod;
            OP_SHL:    alu = a_reg << b_reg[4:0];
            OP_SHR:    alu = DATA_W'($signed(a_reg) >>> b_reg[4:0]);
            OP_EQ:     alu = DATA_W'(eq);
            OP_NE:     alu = DATA_W'(!eq);
            OP_LT:     alu = DATA_W'(lt);
            OP_LE:     alu = DATA_W'(lt || eq);
            OP_GT:     alu = DATA_W'(!lt && !eq);
            OP_GE:     alu = DATA_W'(!lt);
            OP_AND:    alu = a_reg & b_reg;
            OP_OR:     alu = a_reg | b_reg;
            OP_XOR:    alu = a_reg ^ b_reg;
            OP_LAND:   alu = DATA_W'(a_reg != '0 && b_reg != '0);
            OP_LOR:    alu = DATA_W'(a_reg != '0 || b_reg != '0);
            OP_LNOT:   alu = DATA_W'(a_reg == '0);
            OP_BNOT:   alu = ~a_reg;
            OP_COPY:   alu = a_reg;
            OP_SETVAR: alu = ins_reg.immediate;
            default:   alu = '0;
        endcase
    end

    always_comb
    begin
        case (ins_reg.cmd)
            OP_JMP:    jcond = 1'b1;
            OP_JTRUE:  jcond = a_reg != '0;
            OP_JFALSE: jcond = a_reg == '0;
            default:   jcond = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ins_next   = ins_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        ain_next   = ain_reg;
        bin_next   = bin_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = AW'(ins_reg.dest);
        wr_data    = alu;
        rd_addr    = AW'(ins_reg.src_a);
        dctl       = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg[AW-1:0];
                wr_data = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(NUM_VARS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ins_next   = s_axis_tdata[60:0];
                    state_next = ST_RDA;
                end
            end
            ST_RDA:
            begin
                rd_addr  = AW'(ins_reg.src_a);
                ain_next = {{(32-IDX_W){1'b0}}, ins_reg.src_a} < NUM_VARS;
                state_next = ST_RDB;
            end
            ST_RDB:
            begin
                a_next   = ain_reg ? rd_data : '0;
                rd_addr  = (ins_reg.cmd == OP_PRN) ? AW'(ins_reg.dest)
                                                   : AW'(ins_reg.src_b);
                bin_next = (ins_reg.cmd == OP_PRN) ? dest_in
                         : ({{(32-IDX_W){1'b0}}, ins_reg.src_b} < NUM_VARS);
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                b_next   = bin_reg ? rd_data : '0;
                // from here on bin marks that the divider has been started
                bin_next = 1'b0;
                state_next = ST_OUT;
                res_next = '0;
                case (ins_reg.cmd)
                    OP_DIV, OP_MOD:
                    begin
                        state_next = ST_DIV;
                    end
                    OP_JMP, OP_JTRUE, OP_JFALSE:
                    begin
                        res_next.target_label = ins_reg.dest;
                        res_next.branch_taken = jcond &&
                            ({{(32-IDX_W){1'b0}}, ins_reg.dest} < NUM_LABELS);
                    end
                    OP_PRN:
                    begin
                        res_next.print_valid = 1'b1;
                        res_next.print_value = bin_reg ? rd_data : '0;
                    end
                    OP_END:
                    begin
                        res_next.halt = 1'b1;
                    end
                    OP_LBL:
                    begin
                        res_next.halt = 1'b0;
                    end
                    default:
                    begin
                        state_next = ST_DIV;
                    end
                endcase
                if (ins_reg.cmd == OP_DIV || ins_reg.cmd == OP_MOD)
                begin
                    state_next = ST_DIV;
                end
                else if (ins_reg.cmd <= OP_BNOT || ins_reg.cmd == OP_COPY ||
                         ins_reg.cmd == OP_SETVAR)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                // b now settled; ALU ops write back here, div/mod wait here
                if (ins_reg.cmd == OP_DIV || ins_reg.cmd == OP_MOD)
                begin
                    if (!bin_reg)
                    begin
                        bin_next = 1'b1;
                        dctl.start  = 1'b1;
                        dctl.is_mod = ins_reg.cmd == OP_MOD;
                    end
                    else if (dsts.done)
                    begin
                        res_next.arith_error = dsts.err;
                        wr_en   = !dsts.err && dest_in;
                        wr_data = dsts.value;
                        state_next = ST_OUT;
                    end
                end
                else
                begin
                    wr_en      = dest_in;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg <= ins_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        ain_reg <= ain_next;
        bin_reg <= bin_next;
        res_reg <= res_next;
    end

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = state_reg == ST_OUT;
    assign m_axis_tdata  = {4'b0, res_reg};

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-address execute unit: a directed set of
// opcodes and corner values, then random programs that preload variables and
// run mixed instructions, checked against a local model of the variable file.
// ----------------------------------------------------------------------------
module testbench;

    import taie_pkg::*;

    localparam int LIMIT_CYCLES = 600000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    three_address_ir_execute_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    instr_t      instr_q[$];
    result_t     expected_q[$];
    logic [31:0] var_file[256];
    int          n_fail;
    int          n_results;
    int          n_errors;
    int          n_taken;
    int          n_prints;
    int          cycles;
    bit          src_pause;
    bit          hold_rx;
    bit          stim_done;
    int          burst_left;
    int          gap_left;
    int          stall_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    // predictor: executes one instruction on the local variable file
    function automatic result_t execute_instr(instr_t ins);
        result_t     res;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        bit          wr;
        a   = var_file[ins.src_a];
        b   = var_file[ins.src_b];
        res = '0;
        wr  = 1'b1;
        r   = '0;
        case (ins.cmd)
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_MUL:  r = a * b;
            OP_DIV, OP_MOD:
                if (b == 0 || (a == 32'h8000_0000 && b == 32'hFFFF_FFFF))
                begin
                    res.arith_error = 1'b1;
                    wr = 1'b0;
                end
                else if (ins.cmd == OP_DIV)
                    r = $signed(a) / $signed(b);
                else
                    r = $signed(a) % $signed(b);
            OP_SHL:  r = a << b[4:0];
            OP_SHR:  r = $signed(a) >>> b[4:0];
            OP_EQ:   r = {31'd0, a == b};
            OP_NE:   r = {31'd0, a != b};
            OP_LT:   r = {31'd0, $signed(a) < $signed(b)};
            OP_LE:   r = {31'd0, $signed(a) <= $signed(b)};
            OP_GT:   r = {31'd0, $signed(a) > $signed(b)};
            OP_GE:   r = {31'd0, $signed(a) >= $signed(b)};
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_LAND: r = {31'd0, a != 0 && b != 0};
            OP_LOR:  r = {31'd0, a != 0 || b != 0};
            OP_LNOT: r = {31'd0, a == 0};
            OP_BNOT: r = ~a;
            OP_JMP, OP_JTRUE, OP_JFALSE:
            begin
                wr = 1'b0;
                res.target_label = ins.dest;
                if (ins.cmd == OP_JMP)
                    res.branch_taken = 1'b1;
                else if (ins.cmd == OP_JTRUE)
                    res.branch_taken = a != 0;
                else
                    res.branch_taken = a == 0;
            end
            OP_COPY:   r = a;
            OP_PRN:
            begin
                wr = 1'b0;
                res.print_valid = 1'b1;
                res.print_value = var_file[ins.dest];
            end
            OP_END:
            begin
                wr = 1'b0;
                res.halt = 1'b1;
            end
            OP_SETVAR: r = ins.immediate;
            default:   wr = 1'b0;
        endcase
        if (wr)
            var_file[ins.dest] = r;
        return res;
    endfunction

    function automatic instr_t make_instr(logic [4:0] c, logic [7:0] sa, logic [7:0] sb,
                                          logic [7:0] d, logic [31:0] imm);
        instr_t ins;
        ins.cmd       = c;
        ins.src_a     = sa;
        ins.src_b     = sb;
        ins.dest      = d;
        ins.immediate = imm;
        return ins;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'd0;
            4:       return $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    // random indices mostly land in a small working set so values get reused
    function automatic logic [7:0] rand_idx();
        if ($urandom_range(0, 9) < 8)
            return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic wait_drained();
        while (instr_q.size() != 0 || expected_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
    endtask

    // driver: bursts of transfers with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                expected_q.push_back(execute_instr(instr_t'(s_axis_tdata[60:0])));
            if (gap_left > 0 || src_pause || instr_q.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {3'b0, instr_q.pop_front()};
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 50);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t exp_res;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[43:0]);
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    n_fail++;
                end
                else
                begin
                    exp_res = expected_q.pop_front();
                    n_results++;
                    n_errors += got.arith_error;
                    n_taken  += got.branch_taken;
                    n_prints += got.print_valid;
                    if (got.branch_taken !== exp_res.branch_taken
                        || got.target_label !== exp_res.target_label
                        || got.print_valid !== exp_res.print_valid
                        || got.print_value !== exp_res.print_value
                        || got.halt !== exp_res.halt
                        || got.arith_error !== exp_res.arith_error)
                    begin
                        $display("%0t: mismatch expected tkn=%b lbl=%0d pv=%b val=%h hlt=%b err=%b",
                                 $time, exp_res.branch_taken, exp_res.target_label,
                                 exp_res.print_valid, exp_res.print_value,
                                 exp_res.halt, exp_res.arith_error);
                        $display("%0t:          actual   tkn=%b lbl=%0d pv=%b val=%h hlt=%b err=%b",
                                 $time, got.branch_taken, got.target_label, got.print_valid,
                                 got.print_value, got.halt, got.arith_error);
                        n_fail++;
                    end
                end
            end
            if (hold_rx)
                m_axis_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_left - 1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    <= $urandom_range(0, 12);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_q.size());
            $display("** three_address_ir_execute_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [4:0] c;
        n_fail    = 0;
        n_results = 0;
        n_errors  = 0;
        n_taken   = 0;
        n_prints  = 0;
        cycles    = 0;
        src_pause = 1'b0;
        hold_rx   = 1'b0;
        stim_done = 1'b0;
        for (int i = 0; i < 256; i++)
            var_file[i] = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extreme values, every opcode, division corners
        instr_q.push_back(make_instr(OP_SETVAR, 0, 0, 1, 32'h8000_0000));
        instr_q.push_back(make_instr(OP_SETVAR, 0, 0, 2, 32'hFFFF_FFFF));
        instr_q.push_back(make_instr(OP_SETVAR, 0, 0, 3, 32'h7FFF_FFFF));
        instr_q.push_back(make_instr(OP_SETVAR, 0, 0, 255, 32'h0000_0025));
        instr_q.push_back(make_instr(OP_DIV, 1, 2, 4, 0));
        instr_q.push_back(make_instr(OP_MOD, 1, 2, 4, 0));
        instr_q.push_back(make_instr(OP_DIV, 3, 0, 4, 0));
        instr_q.push_back(make_instr(OP_MOD, 2, 255, 5, 0));
        instr_q.push_back(make_instr(OP_DIV, 1, 255, 6, 0));
        instr_q.push_back(make_instr(OP_ADD, 3, 3, 7, 0));
        instr_q.push_back(make_instr(OP_SHL, 3, 255, 8, 0));
        instr_q.push_back(make_instr(OP_SHR, 1, 255, 9, 0));
        for (int op = 0; op < 32; op++)
        begin
            c = 5'(op);
            if (c != OP_SETVAR)
                instr_q.push_back(make_instr(c, 1, 2, 10, 0));
        end
        instr_q.push_back(make_instr(OP_JTRUE, 0, 0, 255, 0));
        instr_q.push_back(make_instr(OP_JFALSE, 0, 0, 255, 0));
        instr_q.push_back(make_instr(OP_PRN, 0, 0, 255, 0));
        wait_drained();

        // long receiver hold while the sender keeps offering
        hold_rx = 1'b1;
        for (int i = 0; i < 20; i++)
            instr_q.push_back(make_instr(OP_PRN, 0, 0, rand_idx(), 0));
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
        wait_drained();

        // random programs: preload a working set, then mixed operations
        for (int prog = 0; prog < 60; prog++)
        begin
            for (int i = 0; i < 4; i++)
                instr_q.push_back(make_instr(OP_SETVAR, 8'($urandom), 8'($urandom),
                                             rand_idx(), rand_value()));
            for (int i = 0; i < 24; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    c = 5'($urandom_range(0, 31));
                else if ($urandom_range(0, 4) == 0)
                    c = $urandom_range(0, 1) ? OP_DIV : OP_MOD;
                else
                    c = 5'($urandom_range(0, 27));
                instr_q.push_back(make_instr(c, rand_idx(), rand_idx(), rand_idx(),
                                             ($urandom_range(0, 3) == 0) ? rand_value()
                                                                         : $urandom));
            end
            if (prog % 15 == 7)
            begin
                // sender holds back until everything in flight has come out
                src_pause = 1'b1;
                while (expected_q.size() != 0 || s_axis_tvalid)
                    @(posedge clk);
                src_pause = 1'b0;
            end
            while (instr_q.size() > 64)
                @(posedge clk);
        end
        wait_drained();
        repeat (100) @(posedge clk);

        $display("%0d instructions checked: %0d arithmetic errors, %0d branches taken,",
                 n_results, n_errors, n_taken);
        $display("%0d prints, with directed corners and long stalls on both sides", n_prints);
        if (n_fail == 0 && expected_q.size() == 0)
            $display("** three_address_ir_execute_unit: PASSED **");
        else
            $display("** three_address_ir_execute_unit: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
rtl/taie_pkg.sv
rtl/taie_ram.sv
rtl/taie_div.sv
rtl/three_address_ir_execute_unit.sv
tb/sv/testbench.sv
